/* hdl/ppv_pkg.sv */
// ----------------------------------------------------------------------------
// ppv_pkg
// Shared types and constants for the per-price volume profile with EWMAs.
// ----------------------------------------------------------------------------
package ppv_pkg;

  localparam int SEQ_W      = 32;
  localparam int SIDE_W     = 2;
  localparam int PRICE_W    = 24;
  localparam int VOL_W      = 24;
  localparam int TOTAL_W    = 48;
  localparam int EWMA_W     = 40;
  localparam int ALPHA_W    = 16;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 32;
  localparam int OFFSET_W   = 16;   // enough for the largest table
  localparam int ROW_W      = 2 * TOTAL_W + 2 * EWMA_W;
  localparam int PROD_W     = EWMA_W + ALPHA_W;
  localparam int QUEUE_DEPTH = 2;

  localparam int PRICE_LEVELS_DEF  = 1024;
  localparam int FRACTION_BITS_DEF = 16;

  localparam logic [ALPHA_W-1:0] ALPHA_RESET = ALPHA_W'(2232);
  localparam logic [PRICE_W-1:0] BASE_RESET  = '0;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ALPHA = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_BASE  = CFG_IDX_W'(1);

  // side codes
  localparam logic [SIDE_W-1:0] SIDE_ASK = SIDE_W'(0);
  localparam logic [SIDE_W-1:0] SIDE_BID = SIDE_W'(1);

  // result status codes
  localparam logic STAT_UPDATED = 1'b0;
  localparam logic STAT_OUTSIDE = 1'b1;

  // classified trade handed from front to back
  typedef struct packed {
    logic [PRICE_W-1:0]  price;
    logic [VOL_W-1:0]    volume;
    logic [OFFSET_W-1:0] offset;
    logic                is_bid;
    logic                outside;
  } q_item_t;

  typedef enum logic [2:0] {
    B_CLEAR,
    B_IDLE,
    B_READ,
    B_MUL,
    B_WB
  } back_state_t;

endpackage

/* hdl/ppv_ram.sv */
// ----------------------------------------------------------------------------
// ppv_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
module ppv_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

/* hdl/ppv_queue.sv */
// ----------------------------------------------------------------------------
// ppv_queue
// Short FIFO between the classifying front and the table back end.
// ----------------------------------------------------------------------------
module ppv_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  ppv_pkg::q_item_t push_item,
  input  logic             pop,
  output ppv_pkg::q_item_t head,
  output logic             empty,
  output logic             full
);

  import ppv_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  q_item_t           slots [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  count;

  function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
    if (p == PTR_W'(QUEUE_DEPTH - 1)) begin
      return '0;
    end
    return p + PTR_W'(1);
  endfunction

  assign empty = (count == '0);
  assign full  = (count == CNT_W'(QUEUE_DEPTH));
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= bump(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= bump(rd_ptr);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

/* hdl/ppv_front.sv */
// ----------------------------------------------------------------------------
// ppv_front
// Accepts trade records, filters stale sequences and non-trade sides,
// maps the price to a table offset and holds the configuration registers.
// ----------------------------------------------------------------------------
module ppv_front #(
  parameter int PRICE_LEVELS = ppv_pkg::PRICE_LEVELS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic [ppv_pkg::SEQ_W-1:0]         sequence_req,
  input  logic [ppv_pkg::SIDE_W-1:0]        side,
  input  logic [ppv_pkg::PRICE_W-1:0]       price_ticks,
  input  logic [ppv_pkg::VOL_W-1:0]         volume,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [ppv_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [ppv_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                              clearing,
  input  logic                              q_full,
  output logic                              push,
  output ppv_pkg::q_item_t                  push_item,
  output logic [ppv_pkg::ALPHA_W-1:0]       alpha
);

  import ppv_pkg::*;

  logic [SEQ_W-1:0]   last_sequence;
  logic [PRICE_W-1:0] price_base;
  logic [PRICE_W-1:0] offset_full;
  logic               accept;
  logic               is_trade;

  assign cfg_ready = 1'b1;
  assign busy      = clearing || q_full;
  assign accept    = start && !busy;
  assign is_trade  = (sequence_req > last_sequence) &&
                     ((side == SIDE_ASK) || (side == SIDE_BID));
  assign push      = accept && is_trade;

  assign offset_full = price_ticks - price_base;

  always_comb begin
    push_item         = '0;
    push_item.price   = price_ticks;
    push_item.volume  = volume;
    push_item.offset  = offset_full[OFFSET_W-1:0];
    push_item.is_bid  = (side == SIDE_BID);
    push_item.outside = (price_ticks < price_base) ||
                        (offset_full >= PRICE_W'(PRICE_LEVELS));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_sequence <= '0;
      alpha         <= ALPHA_RESET;
      price_base    <= BASE_RESET;
    end else begin
      if (push) begin
        last_sequence <= sequence_req;
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_ALPHA: alpha      <= cfg_data[ALPHA_W-1:0];
          CFG_BASE:  price_base <= cfg_data[PRICE_W-1:0];
          default: ;
        endcase
      end
    end
  end

endmodule

/* hdl/ppv_back.sv */
// ----------------------------------------------------------------------------
// ppv_back
// Table back end: clears the table after reset, then does one
// read-multiply-writeback per in-range trade and drives the result strobe.
// ----------------------------------------------------------------------------
module ppv_back #(
  parameter int PRICE_LEVELS  = ppv_pkg::PRICE_LEVELS_DEF,
  parameter int FRACTION_BITS = ppv_pkg::FRACTION_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  ppv_pkg::q_item_t              head,
  input  logic                          q_empty,
  output logic                          pop,
  output logic                          clearing,
  input  logic [ppv_pkg::ALPHA_W-1:0]   alpha,
  output logic                          done,
  output logic                          status,
  output logic [ppv_pkg::PRICE_W-1:0]   price_ticks_out,
  output logic [ppv_pkg::TOTAL_W-1:0]   total_ask,
  output logic [ppv_pkg::TOTAL_W-1:0]   total_bid,
  output logic [ppv_pkg::EWMA_W-1:0]    ewma_ask,
  output logic [ppv_pkg::EWMA_W-1:0]    ewma_bid
);

  import ppv_pkg::*;

  localparam int IDX_W  = (PRICE_LEVELS > 1) ? $clog2(PRICE_LEVELS) : 1;
  localparam int OBS_XW = VOL_W + 24;   // room for the widest shift

  back_state_t state, state_next;

  logic [IDX_W-1:0]  clr_cnt;
  q_item_t           cur;

  logic              ram_en;
  logic              ram_we;
  logic [IDX_W-1:0]  ram_addr;
  logic [ROW_W-1:0]  ram_wdata;
  logic [ROW_W-1:0]  ram_rdata;

  // read-stage datapath
  logic [TOTAL_W-1:0] rd_tot_ask, rd_tot_bid;
  logic [EWMA_W-1:0]  rd_ew_ask, rd_ew_bid;
  logic [OBS_XW-1:0]  obs_wide;
  logic [EWMA_W-1:0]  obs, obs_ask, obs_bid;
  logic [TOTAL_W:0]   sum_tot;
  logic [TOTAL_W-1:0] sat_tot;

  // registered between stages
  logic [TOTAL_W-1:0] new_tot_ask, new_tot_bid;
  logic [EWMA_W-1:0]  old_ask, old_bid;
  logic [EWMA_W-1:0]  diff_ask, diff_bid;
  logic               up_ask, up_bid;
  logic [PROD_W-1:0]  prod_ask, prod_bid;

  logic [EWMA_W-1:0]  new_ew_ask, new_ew_bid;

  ppv_ram #(
    .WIDTH (ROW_W),
    .DEPTH (PRICE_LEVELS)
  ) u_table (
    .clk   (clk),
    .en    (ram_en),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  assign {rd_tot_ask, rd_tot_bid, rd_ew_ask, rd_ew_bid} = ram_rdata;

  always_comb begin
    obs_wide = OBS_XW'(cur.volume) << FRACTION_BITS;
    obs      = (|obs_wide[OBS_XW-1:EWMA_W]) ? '1 : obs_wide[EWMA_W-1:0];
    obs_ask  = cur.is_bid ? '0 : obs;
    obs_bid  = cur.is_bid ? obs : '0;
    sum_tot  = {1'b0, (cur.is_bid ? rd_tot_bid : rd_tot_ask)} + (TOTAL_W + 1)'(cur.volume);
    sat_tot  = sum_tot[TOTAL_W] ? '1 : sum_tot[TOTAL_W-1:0];
  end

  // writeback: floor of alpha*(obs-old) / 2^16
  function automatic logic [EWMA_W-1:0] ewma_next(
    input logic [EWMA_W-1:0] old,
    input logic              up,
    input logic [PROD_W-1:0] prod
  );
    logic [PROD_W:0] rounded;
    rounded = {1'b0, prod} + (PROD_W + 1)'({ALPHA_W{1'b1}});
    if (up) begin
      return old + prod[PROD_W-1:ALPHA_W];
    end
    return old - rounded[PROD_W-1:ALPHA_W];
  endfunction

  assign new_ew_ask = ewma_next(old_ask, up_ask, prod_ask);
  assign new_ew_bid = ewma_next(old_bid, up_bid, prod_bid);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      B_CLEAR: if (clr_cnt == IDX_W'(PRICE_LEVELS - 1)) state_next = B_IDLE;
      B_IDLE: begin
        if (!q_empty && !head.outside) begin
          state_next = B_READ;
        end
      end
      B_READ:  state_next = B_MUL;
      B_MUL:   state_next = B_WB;
      B_WB:    state_next = B_IDLE;
      default: state_next = B_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    pop       = 1'b0;
    clearing  = 1'b0;
    ram_en    = 1'b0;
    ram_we    = 1'b0;
    ram_addr  = cur.offset[IDX_W-1:0];
    ram_wdata = {new_tot_ask, new_tot_bid, new_ew_ask, new_ew_bid};
    case (state)
      B_CLEAR: begin
        clearing  = 1'b1;
        ram_en    = 1'b1;
        ram_we    = 1'b1;
        ram_addr  = clr_cnt;
        ram_wdata = '0;
      end
      B_IDLE: begin
        pop = !q_empty;
        if (!q_empty && !head.outside) begin
          ram_en   = 1'b1;
          ram_addr = head.offset[IDX_W-1:0];
        end
      end
      B_WB: begin
        ram_en = 1'b1;
        ram_we = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= B_CLEAR;
      clr_cnt <= '0;
      done    <= 1'b0;
    end else begin
      state <= state_next;
      done  <= 1'b0;
      if (state == B_CLEAR) begin
        clr_cnt <= clr_cnt + IDX_W'(1);
      end
      if ((state == B_IDLE && !q_empty && head.outside) || state == B_WB) begin
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      B_IDLE: begin
        if (!q_empty) begin
          cur             <= head;
          status          <= STAT_OUTSIDE;
          price_ticks_out <= head.price;
          total_ask       <= '0;
          total_bid       <= '0;
          ewma_ask        <= '0;
          ewma_bid        <= '0;
        end
      end
      B_READ: begin
        new_tot_ask <= cur.is_bid ? rd_tot_ask : sat_tot;
        new_tot_bid <= cur.is_bid ? sat_tot : rd_tot_bid;
        old_ask     <= rd_ew_ask;
        old_bid     <= rd_ew_bid;
        up_ask      <= (obs_ask >= rd_ew_ask);
        up_bid      <= (obs_bid >= rd_ew_bid);
        diff_ask    <= (obs_ask >= rd_ew_ask) ? obs_ask - rd_ew_ask : rd_ew_ask - obs_ask;
        diff_bid    <= (obs_bid >= rd_ew_bid) ? obs_bid - rd_ew_bid : rd_ew_bid - obs_bid;
      end
      B_MUL: begin
        prod_ask <= PROD_W'(alpha) * PROD_W'(diff_ask);
        prod_bid <= PROD_W'(alpha) * PROD_W'(diff_bid);
      end
      B_WB: begin
        status    <= STAT_UPDATED;
        total_ask <= new_tot_ask;
        total_bid <= new_tot_bid;
        ewma_ask  <= new_ew_ask;
        ewma_bid  <= new_ew_bid;
      end
      default: ;
    endcase
  end

endmodule

/* hdl/per_price_volume_ewma_table.sv */
// ----------------------------------------------------------------------------
// per_price_volume_ewma_table
// Per-price ask/bid volume totals and volume EWMAs, fed by trade records.
// ----------------------------------------------------------------------------
//  channel   handshake               payload
//  -------   ---------------------   ------------------------------------------
//  trade     start & !busy           sequence_req, side, price_ticks, volume
//  result    done (one-cycle beat)   status, price_ticks_out, totals, ewmas
//  config    cfg_valid & cfg_ready   cfg_index, cfg_data
//
//  An in-range trade occupies the back end for the table read, read data,
//  multiply and writeback steps. Result beat follows in the cycle after
//  writeback. A price outside the table gives its beat in the cycle after
//  leaving the queue; filtered records give none. A 2-entry queue lets
//  start be taken while the back end works. After reset, busy stays high
//  while the table is swept to zero. The receiver of done cannot stall.
// ----------------------------------------------------------------------------
module per_price_volume_ewma_table #(
  parameter int PRICE_LEVELS  = ppv_pkg::PRICE_LEVELS_DEF,
  parameter int FRACTION_BITS = ppv_pkg::FRACTION_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  logic [ppv_pkg::SEQ_W-1:0]      sequence_req,
  input  logic [ppv_pkg::SIDE_W-1:0]     side,
  input  logic [ppv_pkg::PRICE_W-1:0]    price_ticks,
  input  logic [ppv_pkg::VOL_W-1:0]      volume,
  output logic                           done,
  output logic                           status,
  output logic [ppv_pkg::PRICE_W-1:0]    price_ticks_out,
  output logic [ppv_pkg::TOTAL_W-1:0]    total_ask,
  output logic [ppv_pkg::TOTAL_W-1:0]    total_bid,
  output logic [ppv_pkg::EWMA_W-1:0]     ewma_ask,
  output logic [ppv_pkg::EWMA_W-1:0]     ewma_bid,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [ppv_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ppv_pkg::CFG_DATA_W-1:0] cfg_data
);

  import ppv_pkg::*;

  logic               clearing;
  logic               q_full;
  logic               q_empty;
  logic               push;
  logic               pop;
  q_item_t            push_item;
  q_item_t            head;
  logic [ALPHA_W-1:0] alpha;

  ppv_front #(
    .PRICE_LEVELS (PRICE_LEVELS)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .sequence_req (sequence_req),
    .side         (side),
    .price_ticks  (price_ticks),
    .volume       (volume),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .clearing     (clearing),
    .q_full       (q_full),
    .push         (push),
    .push_item    (push_item),
    .alpha        (alpha)
  );

  ppv_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head      (head),
    .empty     (q_empty),
    .full      (q_full)
  );

  ppv_back #(
    .PRICE_LEVELS  (PRICE_LEVELS),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_back (
    .clk             (clk),
    .rst             (rst),
    .head            (head),
    .q_empty         (q_empty),
    .pop             (pop),
    .clearing        (clearing),
    .alpha           (alpha),
    .done            (done),
    .status          (status),
    .price_ticks_out (price_ticks_out),
    .total_ask       (total_ask),
    .total_bid       (total_bid),
    .ewma_ask        (ewma_ask),
    .ewma_bid        (ewma_bid)
  );

endmodule
